FILE: sv/fca_pkg.sv
// Shared constants, types and the arctangent table for the fly camera block.
// No dependencies; compiled first.
`default_nettype none

package fca_pkg;

  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;
  localparam int PITCH_LIM    = 5696;
  localparam int ONE_Q14      = 16384;

  localparam logic [15:0] MOVE_SPEED_RST  = 16'd640;
  localparam logic [15:0] LOOK_GAIN_RST   = 16'd6554;
  localparam logic [14:0] START_YAW_RST   = 15'd17280;
  localparam logic [13:0] START_PITCH_RST = 14'd0;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
  localparam int CORDIC_XW    = 20;
  localparam int CORDIC_ZW    = 24;
  localparam int CORDIC_X0    = 39797;

  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic signed [MUL_P_W-1:0] RND8  = MUL_P_W'(128);
  localparam logic signed [MUL_P_W-1:0] RND14 = MUL_P_W'(8192);
  localparam logic signed [MUL_P_W-1:0] RND16 = MUL_P_W'(32768);

  localparam logic [1:0] KIND_MOVE = 2'd0;
  localparam logic [1:0] KIND_LOOK = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;

  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  typedef enum logic [1:0] {
    REG_MOVE_SPEED,
    REG_LOOK_GAIN,
    REG_START_YAW,
    REG_START_PITCH
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        move_speed;
    logic [15:0]        look_gain;
    logic               yaw_load;
    logic [14:0]        start_yaw;
    logic               pitch_load;
    logic signed [13:0] start_pitch;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } res_t;

  // arctan(2^-i) in 1/16384 degree
  function automatic logic signed [CORDIC_ZW-1:0] atan_step(input logic [CORDIC_IW-1:0] i);
    logic signed [CORDIC_ZW-1:0] v;
    case (i)
      4'd0:    v = CORDIC_ZW'(737280);
      4'd1:    v = CORDIC_ZW'(435242);
      4'd2:    v = CORDIC_ZW'(229970);
      4'd3:    v = CORDIC_ZW'(116736);
      4'd4:    v = CORDIC_ZW'(58595);
      4'd5:    v = CORDIC_ZW'(29326);
      4'd6:    v = CORDIC_ZW'(14667);
      4'd7:    v = CORDIC_ZW'(7334);
      4'd8:    v = CORDIC_ZW'(3667);
      4'd9:    v = CORDIC_ZW'(1833);
      4'd10:   v = CORDIC_ZW'(917);
      4'd11:   v = CORDIC_ZW'(458);
      4'd12:   v = CORDIC_ZW'(229);
      4'd13:   v = CORDIC_ZW'(115);
      4'd14:   v = CORDIC_ZW'(57);
      default: v = CORDIC_ZW'(29);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fca_if.sv
// Valid/ready channel interfaces for camera item beats and result beats.
// No dependencies.
`default_nettype none

interface fca_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         direction;
  logic [15:0]        delta_time;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;

  modport source (output valid, kind, direction, delta_time, offset_x, offset_y,
                  new_x, new_y, new_z, input ready);
  modport sink (input valid, kind, direction, delta_time, offset_x, offset_y,
                new_x, new_y, new_z, output ready);
endinterface

interface fca_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;

  modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  right_x, right_z, up_x, up_y, up_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                right_x, right_z, up_x, up_y, up_z, output ready);
endinterface

`default_nettype wire

FILE: sv/free_fly_camera_orientation.sv
// Free-fly camera orientation top level: APB register file and sequencer.
// Depends on fca_pkg, fca_if and fca_seq.
//
// Takes one item beat (move, look or set position) and returns one result beat with the
// Q16.16 position and the Q1.14 front, right and up vectors. One beat is worked at a
// time; in_ch.ready is low while it is in flight. A look runs two CORDIC passes
// (one micro-rotation per cycle), for yaw and then for pitch, after wrapping yaw; the
// products of every kind are formed on the shared 25x18 multiplier. After reset, and
// after any write to start_yaw or start_pitch, the block refreshes the sine and cosine
// values before it takes a beat. A finished result waits in an output register, so the
// next beat is accepted while the previous result is still pending.
`default_nettype none

module free_fly_camera_orientation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fca_in_if.sink           in_ch,
  fca_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import fca_pkg::*;

  logic [15:0]        move_speed_r, move_speed_nxt;
  logic [15:0]        look_gain_r, look_gain_nxt;
  logic [14:0]        start_yaw_r, start_yaw_nxt;
  logic [13:0]        start_pitch_r, start_pitch_nxt;
  logic               wr;
  reg_idx_t           idx;
  cfg_t               cfg;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    move_speed_nxt  = move_speed_r;
    look_gain_nxt   = look_gain_r;
    start_yaw_nxt   = start_yaw_r;
    start_pitch_nxt = start_pitch_r;
    if (wr) begin
      unique case (idx)
        REG_MOVE_SPEED:  move_speed_nxt  = pwdata[15:0];
        REG_LOOK_GAIN:   look_gain_nxt   = pwdata[15:0];
        REG_START_YAW:   start_yaw_nxt   = pwdata[14:0];
        REG_START_PITCH: start_pitch_nxt = pwdata[13:0];
        default:         move_speed_nxt  = move_speed_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_speed_r  <= MOVE_SPEED_RST;
      look_gain_r   <= LOOK_GAIN_RST;
      start_yaw_r   <= START_YAW_RST;
      start_pitch_r <= START_PITCH_RST;
    end else begin
      move_speed_r  <= move_speed_nxt;
      look_gain_r   <= look_gain_nxt;
      start_yaw_r   <= start_yaw_nxt;
      start_pitch_r <= start_pitch_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MOVE_SPEED:  prdata = {16'd0, move_speed_r};
      REG_LOOK_GAIN:   prdata = {16'd0, look_gain_r};
      REG_START_YAW:   prdata = {17'd0, start_yaw_r};
      REG_START_PITCH: prdata = {18'd0, start_pitch_r};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg.move_speed  = move_speed_r;
    cfg.look_gain   = look_gain_r;
    cfg.yaw_load    = wr && (idx == REG_START_YAW);
    cfg.start_yaw   = pwdata[14:0];
    cfg.pitch_load  = wr && (idx == REG_START_PITCH);
    cfg.start_pitch = pwdata[13:0];
  end

  fca_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: sv/fca_mul.sv
// Shared signed multiplier with registered product.
// Depends on fca_pkg.
`default_nettype none

module fca_mul (
  input  wire logic                               clk,
  input  wire logic signed [fca_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [fca_pkg::MUL_B_W-1:0] b,
  output      logic signed [fca_pkg::MUL_P_W-1:0] prod
);
  import fca_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: sv/fca_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of an angle in 1/64 degree.
// One micro-rotation per cycle. Depends on fca_pkg.
`default_nettype none

module fca_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] angle,
  output      logic               done,
  output      logic signed [15:0] sin_val,
  output      logic signed [15:0] cos_val
);
  import fca_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t                     state_r, state_nxt;
  logic signed [CORDIC_XW-1:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [CORDIC_ZW-1:0] z_r, z_nxt;
  logic [CORDIC_IW-1:0]        i_r, i_nxt;
  logic                        neg_r, neg_nxt, neg_in;
  logic                        done_r, done_nxt;
  logic signed [15:0]          sin_r, sin_nxt, cos_r, cos_nxt;
  logic signed [16:0]          t0, t1;

  function automatic logic signed [15:0] post(input logic signed [CORDIC_XW-1:0] v,
                                              input logic neg);
    logic signed [CORDIC_XW-1:0] r;
    r = (v + CORDIC_XW'(2)) >>> 2;
    if (r > CORDIC_XW'(ONE_Q14)) r = CORDIC_XW'(ONE_Q14);
    else if (r < -CORDIC_XW'(ONE_Q14)) r = -CORDIC_XW'(ONE_Q14);
    if (neg) r = -r;
    return r[15:0];
  endfunction

  // quadrant folding into [-90, 90] degrees
  always_comb begin
    t0 = (angle < 0) ? 17'(angle) + 17'(FULL_TURN) : 17'(angle);
    neg_in = 1'b0;
    if (t0 > 17'(QUARTER_TURN) && t0 <= 17'(FULL_TURN - QUARTER_TURN)) begin
      t1 = t0 - 17'(HALF_TURN);
      neg_in = 1'b1;
    end else if (t0 > 17'(FULL_TURN - QUARTER_TURN)) begin
      t1 = t0 - 17'(FULL_TURN);
    end else begin
      t1 = t0;
    end
  end

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    i_nxt     = i_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    sin_nxt   = sin_r;
    cos_nxt   = cos_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          x_nxt     = CORDIC_XW'(CORDIC_X0);
          y_nxt     = '0;
          z_nxt     = CORDIC_ZW'(t1) <<< 8;
          i_nxt     = '0;
          neg_nxt   = neg_in;
          state_nxt = C_RUN;
        end
      end
      C_RUN: begin
        if (!z_r[CORDIC_ZW-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_step(i_r);
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_step(i_r);
        end
        i_nxt = i_r + 1'b1;
        if (i_r == CORDIC_IW'(CORDIC_STEPS - 1)) state_nxt = C_FIN;
      end
      C_FIN: begin
        sin_nxt   = post(y_r, neg_r);
        cos_nxt   = post(x_r, neg_r);
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    i_r   <= i_nxt;
    neg_r <= neg_nxt;
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign done    = done_r;
  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

`default_nettype wire

FILE: sv/fca_seq.sv
// Camera sequencer: holds position, angles and trig values, drives the shared
// multiplier and CORDIC, and registers result beats. Depends on fca_pkg,
// fca_if, fca_mul and fca_cordic.
`default_nettype none

module fca_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fca_pkg::cfg_t cfg,
  fca_in_if.sink             in_ch,
  fca_out_if.source          out_ch
);
  import fca_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LK_MY, S_LK_MP, S_LK_PIT, S_LK_WRAP,
    S_TY_GO, S_TY_WAIT, S_TP_GO, S_TP_WAIT,
    S_V_FX, S_V_FZ, S_V_UX, S_V_UZ, S_V_END,
    S_MV_V, S_MV_VR, S_MV_MUL, S_MV_ADD, S_MV_UP, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic               pend_r, pend_nxt, item_r, item_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [2:0]         dir_r, dir_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic signed [15:0] offx_r, offx_nxt, offy_r, offy_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [14:0]        yaw_r, yaw_nxt;
  logic signed [13:0] pitch_r, pitch_nxt;
  logic signed [17:0] ysum_r, ysum_nxt, psum;
  logic signed [15:0] sy_r, sy_nxt, cy_r, cy_nxt, sp_r, sp_nxt, cp_r, cp_nxt;
  logic signed [15:0] fx_r, fx_nxt, fz_r, fz_nxt, ux_r, ux_nxt, uz_r, uz_nxt;
  logic [23:0]        v_r, v_nxt;
  logic [1:0]         k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b, comp;
  logic signed [MUL_P_W-1:0] prod, r8, r14, r16;
  logic signed [16:0]        dang;
  logic signed [15:0]        vec_q;
  logic signed [25:0]        dpos;
  logic signed [31:0]        pk;
  logic                      sub;
  logic [15:0]               yaw_ld;
  logic                      in_acc;
  logic                      c_start, c_done;
  logic signed [15:0]        c_angle, c_sin, c_cos;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [25:0] d,
                                                 input logic sub_d);
    logic signed [33:0] s;
    s = sub_d ? 34'(p) - 34'(d) : 34'(p) + 34'(d);
    if (s > 34'sd2147483647) return {1'b0, {31{1'b1}}};
    if (s < -34'sd2147483648) return {1'b1, {31{1'b0}}};
    return s[31:0];
  endfunction

  fca_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fca_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (c_start),
    .angle   (c_angle),
    .done    (c_done),
    .sin_val (c_sin),
    .cos_val (c_cos)
  );

  assign c_start = (state_r == S_TY_GO) || (state_r == S_TP_GO);
  assign c_angle = (state_r == S_TY_GO) ? $signed({1'b0, yaw_r}) : 16'(pitch_r);

  assign r8    = prod + RND8;
  assign r14   = prod + RND14;
  assign r16   = prod + RND16;
  assign dang  = r16[32:16];
  assign vec_q = r14[29:14];
  assign dpos  = r14[39:14];
  assign psum  = 18'(pitch_r) + 18'(dang);
  assign yaw_ld = {1'b0, cfg.start_yaw};

  assign in_ch.ready = (state_r == S_IDLE) && !pend_r;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    case (k_r)
      2'd0:    comp = dir_r[1] ? -(18'(sy_r)) : 18'(fx_r);
      2'd1:    comp = dir_r[1] ? '0 : 18'(sp_r);
      default: comp = dir_r[1] ? 18'(cy_r) : 18'(fz_r);
    endcase
    case (k_r)
      2'd0:    pk = px_r;
      2'd1:    pk = py_r;
      default: pk = pz_r;
    endcase
    sub = (dir_r == DIR_BACK) || (dir_r == DIR_LEFT);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LK_MY: begin
        mul_a = MUL_A_W'(offx_r);
        mul_b = {2'b00, cfg.look_gain};
      end
      S_LK_MP: begin
        mul_a = MUL_A_W'(offy_r);
        mul_b = {2'b00, cfg.look_gain};
      end
      S_V_FX: begin
        mul_a = MUL_A_W'(cy_r);
        mul_b = MUL_B_W'(cp_r);
      end
      S_V_FZ: begin
        mul_a = MUL_A_W'(sy_r);
        mul_b = MUL_B_W'(cp_r);
      end
      S_V_UX: begin
        mul_a = -(MUL_A_W'(cy_r));
        mul_b = MUL_B_W'(sp_r);
      end
      S_V_UZ: begin
        mul_a = -(MUL_A_W'(sy_r));
        mul_b = MUL_B_W'(sp_r);
      end
      S_MV_V: begin
        mul_a = {9'd0, cfg.move_speed};
        mul_b = {2'b00, dt_r};
      end
      S_MV_MUL: begin
        mul_a = {1'b0, v_r};
        mul_b = comp;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    item_nxt      = item_r;
    kind_nxt      = kind_r;
    dir_nxt       = dir_r;
    dt_nxt        = dt_r;
    offx_nxt      = offx_r;
    offy_nxt      = offy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    yaw_nxt       = yaw_r;
    pitch_nxt     = pitch_r;
    ysum_nxt      = ysum_r;
    sy_nxt        = sy_r;
    cy_nxt        = cy_r;
    sp_nxt        = sp_r;
    cp_nxt        = cp_r;
    fx_nxt        = fx_r;
    fz_nxt        = fz_r;
    ux_nxt        = ux_r;
    uz_nxt        = uz_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_ch.kind;
          dir_nxt  = in_ch.direction;
          dt_nxt   = in_ch.delta_time;
          offx_nxt = in_ch.offset_x;
          offy_nxt = in_ch.offset_y;
          item_nxt = 1'b1;
          if (in_ch.kind == KIND_SET) begin
            px_nxt = in_ch.new_x;
            py_nxt = in_ch.new_y;
            pz_nxt = in_ch.new_z;
          end
          state_nxt = (in_ch.kind == KIND_LOOK) ? S_LK_MY : S_V_FX;
        end else if (pend_r) begin
          pend_nxt  = 1'b0;
          item_nxt  = 1'b0;
          state_nxt = S_TY_GO;
        end
      end
      S_LK_MY: state_nxt = S_LK_MP;
      S_LK_MP: begin
        ysum_nxt  = $signed({3'b000, yaw_r}) + 18'(dang);
        state_nxt = S_LK_PIT;
      end
      S_LK_PIT: begin
        if (psum > 18'(PITCH_LIM)) pitch_nxt = 14'(PITCH_LIM);
        else if (psum < -18'(PITCH_LIM)) pitch_nxt = -14'(PITCH_LIM);
        else pitch_nxt = psum[13:0];
        state_nxt = S_LK_WRAP;
      end
      S_LK_WRAP: begin
        if (ysum_r < 0) begin
          ysum_nxt = ysum_r + 18'(FULL_TURN);
        end else if (ysum_r >= 18'(FULL_TURN)) begin
          ysum_nxt = ysum_r - 18'(FULL_TURN);
        end else begin
          yaw_nxt   = ysum_r[14:0];
          state_nxt = S_TY_GO;
        end
      end
      S_TY_GO: state_nxt = S_TY_WAIT;
      S_TY_WAIT: begin
        if (c_done) begin
          sy_nxt    = c_sin;
          cy_nxt    = c_cos;
          state_nxt = S_TP_GO;
        end
      end
      S_TP_GO: state_nxt = S_TP_WAIT;
      S_TP_WAIT: begin
        if (c_done) begin
          sp_nxt    = c_sin;
          cp_nxt    = c_cos;
          state_nxt = item_r ? S_V_FX : S_IDLE;
        end
      end
      S_V_FX: state_nxt = S_V_FZ;
      S_V_FZ: begin
        fx_nxt    = vec_q;
        state_nxt = S_V_UX;
      end
      S_V_UX: begin
        fz_nxt    = vec_q;
        state_nxt = S_V_UZ;
      end
      S_V_UZ: begin
        ux_nxt    = vec_q;
        state_nxt = S_V_END;
      end
      S_V_END: begin
        uz_nxt    = vec_q;
        state_nxt = (kind_r == KIND_MOVE) ? S_MV_V : S_DONE;
      end
      S_MV_V: state_nxt = S_MV_VR;
      S_MV_VR: begin
        v_nxt = r8[31:8];
        k_nxt = '0;
        if (dir_r == DIR_FWD || dir_r == DIR_BACK || dir_r == DIR_LEFT ||
            dir_r == DIR_RIGHT) begin
          state_nxt = S_MV_MUL;
        end else if (dir_r == DIR_UP || dir_r == DIR_DOWN) begin
          state_nxt = S_MV_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MV_MUL: state_nxt = S_MV_ADD;
      S_MV_ADD: begin
        case (k_r)
          2'd0:    px_nxt = sat_add(pk, dpos, sub);
          2'd1:    py_nxt = sat_add(pk, dpos, sub);
          default: pz_nxt = sat_add(pk, dpos, sub);
        endcase
        if (k_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MV_MUL;
        end
      end
      S_MV_UP: begin
        py_nxt    = sat_add(py_r, $signed({2'b00, v_r}), dir_r == DIR_DOWN);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          res_nxt.pos_x   = px_r;
          res_nxt.pos_y   = py_r;
          res_nxt.pos_z   = pz_r;
          res_nxt.front_x = fx_r;
          res_nxt.front_y = sp_r;
          res_nxt.front_z = fz_r;
          res_nxt.right_x = -sy_r;
          res_nxt.right_z = cy_r;
          res_nxt.up_x    = ux_r;
          res_nxt.up_y    = cp_r;
          res_nxt.up_z    = uz_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // start angle writes reload the angle and queue a trig refresh
    if (cfg.yaw_load) begin
      yaw_nxt  = (yaw_ld >= 16'(FULL_TURN)) ? 15'(yaw_ld - 16'(FULL_TURN)) : cfg.start_yaw;
      pend_nxt = 1'b1;
    end
    if (cfg.pitch_load) begin
      if (cfg.start_pitch > 14'(PITCH_LIM)) pitch_nxt = 14'(PITCH_LIM);
      else if (cfg.start_pitch < -14'(PITCH_LIM)) pitch_nxt = -14'(PITCH_LIM);
      else pitch_nxt = cfg.start_pitch;
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b1;
      item_r      <= 1'b0;
      out_valid_r <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
      pz_r        <= '0;
      yaw_r       <= START_YAW_RST;
      pitch_r     <= START_PITCH_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      item_r      <= item_nxt;
      out_valid_r <= out_valid_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      pz_r        <= pz_nxt;
      yaw_r       <= yaw_nxt;
      pitch_r     <= pitch_nxt;
    end
    kind_r <= kind_nxt;
    dir_r  <= dir_nxt;
    dt_r   <= dt_nxt;
    offx_r <= offx_nxt;
    offy_r <= offy_nxt;
    ysum_r <= ysum_nxt;
    sy_r   <= sy_nxt;
    cy_r   <= cy_nxt;
    sp_r   <= sp_nxt;
    cp_r   <= cp_nxt;
    fx_r   <= fx_nxt;
    fz_r   <= fz_nxt;
    ux_r   <= ux_nxt;
    uz_r   <= uz_nxt;
    v_r    <= v_nxt;
    k_r    <= k_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = res_r.pos_x;
  assign out_ch.pos_y   = res_r.pos_y;
  assign out_ch.pos_z   = res_r.pos_z;
  assign out_ch.front_x = res_r.front_x;
  assign out_ch.front_y = res_r.front_y;
  assign out_ch.front_z = res_r.front_z;
  assign out_ch.right_x = res_r.right_x;
  assign out_ch.right_z = res_r.right_z;
  assign out_ch.up_x    = res_r.up_x;
  assign out_ch.up_y    = res_r.up_y;
  assign out_ch.up_z    = res_r.up_z;

endmodule

`default_nettype wire

FILE: tb/tb_free_fly_camera_orientation.sv
// Self-checking testbench for free_fly_camera_orientation: directed and random item
// beats with register phases, each result beat checked against an in-bench camera model.
// Depends on fca_pkg, fca_if and the block's RTL.
`timescale 1ns / 1ps

module tb_free_fly_camera_orientation;
  import fca_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [2:0] DIR_NONE6 = 3'd6;
  localparam logic [2:0] DIR_NONE7 = 3'd7;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] P_MIN = 32'sh8000_0000;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int TAIL_CYCLES     = 64;
  localparam int MAX_PRINTS      = 200;

  localparam longint ATAN_Q14DEG [16] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29
  };

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         direction;
    logic [15:0]        delta_time;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
  } cam_item_t;

  typedef struct packed {
    cam_item_t          item;
    logic               pos_known;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fca_in_if  in_ch ();
  fca_out_if out_ch ();

  free_fly_camera_orientation u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // camera model state
  longint      cam_pos [3];
  longint      yaw_a, pitch_a;
  longint      sin_yaw, cos_yaw, sin_pit, cos_pit;
  logic [15:0] cur_speed, cur_gain;

  res_t        view_q [$];
  int          err_count;
  int          beat_no;
  int          idle_cycles;

  logic        in_fire, in_rdy, apb_fire;
  logic        quiet;
  logic        drv_pos_known;
  logic signed [31:0] drv_px, drv_py, drv_pz;

  stim_row_t   dir_rows [$];
  cam_item_t   mon_item;
  res_t        mon_got, mon_want;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint rnd_sh(input longint x, input int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clampl(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
    longint t, x, y, z, dx, dy;
    logic   neg;
    t = ang % FULL_TURN;
    if (t < 0) t += FULL_TURN;
    neg = 1'b0;
    if (t > QUARTER_TURN && t <= FULL_TURN - QUARTER_TURN) begin
      t -= HALF_TURN;
      neg = 1'b1;
    end else if (t > FULL_TURN - QUARTER_TURN) begin
      t -= FULL_TURN;
    end
    x = CORDIC_X0;
    y = 0;
    z = t * 256;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q14DEG[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q14DEG[i];
      end
    end
    x = clampl(rnd_sh(x, 2), -ONE_Q14, ONE_Q14);
    y = clampl(rnd_sh(y, 2), -ONE_Q14, ONE_Q14);
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic refresh_trig();
    cordic_sin_cos(yaw_a, sin_yaw, cos_yaw);
    cordic_sin_cos(pitch_a, sin_pit, cos_pit);
  endtask

  task automatic reset_camera();
    cur_speed = MOVE_SPEED_RST;
    cur_gain  = LOOK_GAIN_RST;
    for (int k = 0; k < 3; k++) cam_pos[k] = 0;
    yaw_a   = longint'(START_YAW_RST) % FULL_TURN;
    pitch_a = clampl(longint'($signed(START_PITCH_RST)), -PITCH_LIM, PITCH_LIM);
    refresh_trig();
  endtask

  task automatic write_camera_reg(input logic [3:0] addr, input logic [31:0] data);
    case (reg_idx_t'(addr[3:2]))
      REG_MOVE_SPEED: cur_speed = data[15:0];
      REG_LOOK_GAIN:  cur_gain = data[15:0];
      REG_START_YAW: begin
        yaw_a = longint'(data[14:0]) % FULL_TURN;
        refresh_trig();
      end
      REG_START_PITCH: begin
        pitch_a = clampl(longint'($signed(data[13:0])), -PITCH_LIM, PITCH_LIM);
        refresh_trig();
      end
      default: ;
    endcase
  endtask

  task automatic advance_camera(input cam_item_t it);
    longint v, df, dr, dyaw, dpit, t;
    longint fv [3];
    longint rv [3];
    fv[0] = rnd_sh(cos_yaw * cos_pit, 14);
    fv[1] = sin_pit;
    fv[2] = rnd_sh(sin_yaw * cos_pit, 14);
    rv[0] = -sin_yaw;
    rv[1] = 0;
    rv[2] = cos_yaw;
    case (it.kind)
      KIND_MOVE: begin
        v = rnd_sh(longint'(cur_speed) * longint'(it.delta_time), 8);
        for (int k = 0; k < 3; k++) begin
          df = rnd_sh(v * fv[k], 14);
          dr = rnd_sh(v * rv[k], 14);
          case (it.direction)
            DIR_FWD:   cam_pos[k] = clampl(cam_pos[k] + df, POS_MIN, POS_MAX);
            DIR_BACK:  cam_pos[k] = clampl(cam_pos[k] - df, POS_MIN, POS_MAX);
            DIR_LEFT:  cam_pos[k] = clampl(cam_pos[k] - dr, POS_MIN, POS_MAX);
            DIR_RIGHT: cam_pos[k] = clampl(cam_pos[k] + dr, POS_MIN, POS_MAX);
            default: ;
          endcase
        end
        if (it.direction == DIR_UP) cam_pos[1] = clampl(cam_pos[1] + v, POS_MIN, POS_MAX);
        else if (it.direction == DIR_DOWN) cam_pos[1] = clampl(cam_pos[1] - v, POS_MIN, POS_MAX);
      end
      KIND_LOOK: begin
        dyaw = rnd_sh(longint'(it.offset_x) * longint'(cur_gain), 16);
        dpit = rnd_sh(longint'(it.offset_y) * longint'(cur_gain), 16);
        t = (yaw_a + dyaw) % FULL_TURN;
        if (t < 0) t += FULL_TURN;
        yaw_a = t;
        pitch_a = clampl(pitch_a + dpit, -PITCH_LIM, PITCH_LIM);
        refresh_trig();
      end
      KIND_SET: begin
        cam_pos[0] = it.new_x;
        cam_pos[1] = it.new_y;
        cam_pos[2] = it.new_z;
      end
      default: ;
    endcase
  endtask

  function automatic res_t camera_view();
    res_t r;
    r.pos_x   = 32'(cam_pos[0]);
    r.pos_y   = 32'(cam_pos[1]);
    r.pos_z   = 32'(cam_pos[2]);
    r.front_x = 16'(rnd_sh(cos_yaw * cos_pit, 14));
    r.front_y = 16'(sin_pit);
    r.front_z = 16'(rnd_sh(sin_yaw * cos_pit, 14));
    r.right_x = 16'(-sin_yaw);
    r.right_z = 16'(cos_yaw);
    r.up_x    = 16'(rnd_sh(-(cos_yaw * sin_pit), 14));
    r.up_y    = 16'(cos_pit);
    r.up_z    = 16'(rnd_sh(-(sin_yaw * sin_pit), 14));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < MAX_PRINTS)
      $display("ERROR beat %0d %s: got %0d want %0d", beat_no, what, got, want);
    err_count++;
  endtask

  task automatic check_view(input res_t got, input res_t want);
    string  nm [11] = '{"pos_x", "pos_y", "pos_z", "front_x", "front_y", "front_z",
                        "right_x", "right_z", "up_x", "up_y", "up_z"};
    longint g [11];
    longint w [11];
    g = '{got.pos_x, got.pos_y, got.pos_z, got.front_x, got.front_y, got.front_z,
          got.right_x, got.right_z, got.up_x, got.up_y, got.up_z};
    w = '{want.pos_x, want.pos_y, want.pos_z, want.front_x, want.front_y, want.front_z,
          want.right_x, want.right_z, want.up_x, want.up_y, want.up_z};
    for (int i = 0; i < 11; i++)
      if (g[i] != w[i]) report_mismatch(nm[i], g[i], w[i]);
  endtask

  // model and scoreboard, sampled at the rising edge
  always @(posedge clk) begin
    in_fire  = in_ch.valid && in_ch.ready;
    in_rdy   = in_ch.ready;
    apb_fire = psel && penable && pwrite && pready;
    if (!rst_n) begin
      reset_camera();
    end else begin
      if (apb_fire) write_camera_reg(paddr, pwdata);
      if (in_fire) begin
        mon_item.kind       = in_ch.kind;
        mon_item.direction  = in_ch.direction;
        mon_item.delta_time = in_ch.delta_time;
        mon_item.offset_x   = in_ch.offset_x;
        mon_item.offset_y   = in_ch.offset_y;
        mon_item.new_x      = in_ch.new_x;
        mon_item.new_y      = in_ch.new_y;
        mon_item.new_z      = in_ch.new_z;
        advance_camera(mon_item);
        mon_want = camera_view();
        if (drv_pos_known) begin
          mon_want.pos_x = drv_px;
          mon_want.pos_y = drv_py;
          mon_want.pos_z = drv_pz;
        end
        view_q.push_back(mon_want);
      end
      if (out_ch.valid && out_ch.ready) begin
        mon_got.pos_x   = out_ch.pos_x;
        mon_got.pos_y   = out_ch.pos_y;
        mon_got.pos_z   = out_ch.pos_z;
        mon_got.front_x = out_ch.front_x;
        mon_got.front_y = out_ch.front_y;
        mon_got.front_z = out_ch.front_z;
        mon_got.right_x = out_ch.right_x;
        mon_got.right_z = out_ch.right_z;
        mon_got.up_x    = out_ch.up_x;
        mon_got.up_y    = out_ch.up_y;
        mon_got.up_z    = out_ch.up_z;
        if (view_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          check_view(mon_got, view_q.pop_front());
        end
        beat_no++;
      end
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic stim_row_t stim_row(
    input logic [1:0] kind, input logic [2:0] dir, input logic [15:0] dt,
    input logic signed [15:0] ox, input logic signed [15:0] oy,
    input logic signed [31:0] nx, input logic signed [31:0] ny, input logic signed [31:0] nz,
    input logic known,
    input logic signed [31:0] px, input logic signed [31:0] py, input logic signed [31:0] pz);
    stim_row_t s;
    s.item.kind       = kind;
    s.item.direction  = dir;
    s.item.delta_time = dt;
    s.item.offset_x   = ox;
    s.item.offset_y   = oy;
    s.item.new_x      = nx;
    s.item.new_y      = ny;
    s.item.new_z      = nz;
    s.pos_known       = known;
    s.px              = px;
    s.py              = py;
    s.pz              = pz;
    return s;
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0:       return {12'h7FF, r[19:0]};
      1:       return {12'h800, r[19:0]};
      default: return r;
    endcase
  endfunction

  function automatic cam_item_t rand_item();
    cam_item_t   it;
    logic [31:0] r;
    int          p;
    p = $urandom_range(0, 99);
    it.kind = (p < 45) ? KIND_MOVE : (p < 80) ? KIND_LOOK : (p < 95) ? KIND_SET : KIND_NONE;
    it.direction = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 5))
                                              : 3'($urandom_range(6, 7));
    r = $urandom;
    it.delta_time = ($urandom_range(0, 3) == 0) ? {8'h00, r[7:0]} : r[31:16];
    r = $urandom;
    it.offset_x = ($urandom_range(0, 3) == 0) ? 16'($signed(r[9:0])) : r[15:0];
    it.offset_y = ($urandom_range(0, 3) == 0) ? 16'($signed(r[25:16])) : r[31:16];
    it.new_x = rand_coord();
    it.new_y = rand_coord();
    it.new_z = rand_coord();
    return it;
  endfunction

  task automatic send_item(input cam_item_t it, input logic known,
                           input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] pz);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= it.kind;
    in_ch.direction  <= it.direction;
    in_ch.delta_time <= it.delta_time;
    in_ch.offset_x   <= it.offset_x;
    in_ch.offset_y   <= it.offset_y;
    in_ch.new_x      <= it.new_x;
    in_ch.new_y      <= it.new_y;
    in_ch.new_z      <= it.new_z;
    drv_pos_known    <= known;
    drv_px           <= px;
    drv_py           <= py;
    drv_pz           <= pz;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (view_q.size() != 0);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!apb_fire);
    psel    <= 1'b0;
    penable <= 1'b0;
    // start angle writes trigger a trig refresh; wait it out
    if (idx == REG_START_YAW || idx == REG_START_PITCH) begin
      do @(negedge clk); while (in_rdy);
      do @(negedge clk); while (!in_rdy);
    end
  endtask

  task automatic apply_phase_cfg(input int ph);
    logic [15:0] spd, gain;
    logic [14:0] yaw;
    logic [13:0] pit;
    logic [31:0] r;
    case (ph)
      0: begin spd = 16'hFFFF; gain = 16'hFFFF; yaw = 15'd23039; pit = 14'sd5696; end
      1: begin spd = 16'h0000; gain = 16'h0000; yaw = 15'd0; pit = -14'sd5696; end
      2: begin spd = 16'($urandom); gain = 16'($urandom); yaw = 15'h7FFF; pit = 14'h1FFF; end
      3: begin spd = 16'd256; gain = LOOK_GAIN_RST; yaw = 15'd11520; pit = 14'h2000; end
      default: begin
        spd  = 16'($urandom);
        gain = 16'($urandom);
        yaw  = 15'($urandom_range(0, 32767));
        pit  = 14'($urandom);
      end
    endcase
    r = $urandom;
    cfg_write(REG_MOVE_SPEED, {r[31:16], spd});
    cfg_write(REG_LOOK_GAIN, {r[15:0], gain});
    r = $urandom;
    cfg_write(REG_START_YAW, {r[31:15], yaw});
    cfg_write(REG_START_PITCH, {r[17:0], pit});
  endtask

  initial begin
    err_count        = 0;
    beat_no          = 0;
    quiet            = 1'b0;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_MOVE;
    in_ch.direction  = DIR_FWD;
    in_ch.delta_time = '0;
    in_ch.offset_x   = '0;
    in_ch.offset_y   = '0;
    in_ch.new_x      = '0;
    in_ch.new_y      = '0;
    in_ch.new_z      = '0;
    drv_pos_known    = 1'b0;
    drv_px           = '0;
    drv_py           = '0;
    drv_pz           = '0;

    //                     kind       dir        dt        ox         oy
    //                     nx     ny     nz     known  px     py     pz
    dir_rows.push_back(stim_row(KIND_NONE, DIR_FWD,   16'h0000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b1,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_SET,  DIR_FWD,   16'h0000, 16'sh0000, 16'sh0000,
                                P_MAX, P_MIN, 0,     1'b1,  P_MAX, P_MIN, 0));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_UP,    16'hFFFF, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_SET,  DIR_FWD,   16'h0000, 16'sh0000, 16'sh0000,
                                P_MAX, P_MAX, P_MIN, 1'b1,  P_MAX, P_MAX, P_MIN));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_UP,    16'hFFFF, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b1,  P_MAX, P_MAX, P_MIN));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_DOWN,  16'h0000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b1,  P_MAX, P_MAX, P_MIN));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_NONE6, 16'hFFFF, 16'sh7FFF, 16'sh7FFF,
                                P_MIN, P_MIN, P_MIN, 1'b1,  P_MAX, P_MAX, P_MIN));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_NONE7, 16'hFFFF, 16'sh8000, 16'sh8000,
                                P_MIN, P_MIN, P_MIN, 1'b1,  P_MAX, P_MAX, P_MIN));
    dir_rows.push_back(stim_row(KIND_SET,  DIR_DOWN,  16'hFFFF, 16'sh7FFF, 16'sh8000,
                                0,     0,     0,     1'b1,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_FWD,   16'h8000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_BACK,  16'h8000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_LEFT,  16'h8000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_RIGHT, 16'h8000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_UP,    16'h8000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_DOWN,  16'h8000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_SET,  DIR_FWD,   16'h0000, 16'sh0000, 16'sh0000,
                                P_MIN, P_MIN, P_MIN, 1'b1,  P_MIN, P_MIN, P_MIN));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_BACK,  16'hFFFF, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_MOVE, DIR_DOWN,  16'hFFFF, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_LOOK, DIR_FWD,   16'h0000, 16'sh7FFF, 16'sh7FFF,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_LOOK, DIR_FWD,   16'h0000, 16'sh8000, 16'sh8000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_LOOK, DIR_FWD,   16'h0000, 16'sh0000, 16'sh0000,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_LOOK, DIR_FWD,   16'h0000, -16'sd1,   16'sd1,
                                0,     0,     0,     1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_LOOK, DIR_NONE7, 16'hFFFF, 16'sh4000, -16'sh4000,
                                P_MAX, P_MIN, -1,    1'b0,  0,     0,     0));
    dir_rows.push_back(stim_row(KIND_NONE, DIR_NONE7, 16'hFFFF, -16'sd1,   -16'sd1,
                                -1,    -1,    -1,    1'b0,  0,     0,     0));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_rows.size(); i++)
      send_item(dir_rows[i].item, dir_rows[i].pos_known,
                dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == PHASES - 1) quiet = 1'b1;
      apply_phase_cfg(ph);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 149) == 0) wait_drained();
        send_item(rand_item(), 1'b0, 0, 0, 0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (view_q.size() != 0) report_mismatch("results missing", view_q.size(), 0);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: free_fly_camera_orientation.f
sv/fca_pkg.sv
sv/fca_if.sv
sv/fca_mul.sv
sv/fca_cordic.sv
sv/fca_seq.sv
sv/free_fly_camera_orientation.sv
tb/tb_free_fly_camera_orientation.sv
